// ===== hdl/lps_pkg.sv =====
// Package for the LED pattern sequencer: item kind codes and the status
// group passed from the sequencing core to the stream interface.
// No dependencies.
package lps_pkg;

    // Kind of an input item, carried on s_tuser
    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_TICK = 2'd1,
        FUNC_OFF  = 2'd2
    } lps_func_t;

    localparam int FUNC_W       = 2;
    localparam int STEP_BYTE_W  = 8;
    localparam int UNIT_TICKS_W = 16;
    localparam logic [UNIT_TICKS_W-1:0] UNIT_TICKS_RESET = 16'd1000;

    typedef struct packed {
        logic playing;
        logic load_rejected;
    } lps_status_t;

endpackage

// ===== hdl/lps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lps_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/lps_core.sv =====
// Sequencing core: pattern store, load bookkeeping, step timer and lit mask.
// Depends on lps_pkg and lps_ram.
module lps_core #(
    parameter int PATTERN_DEPTH = 32,
    parameter int CHANNEL_COUNT = 3,
    parameter int DURATION_BITS = 5,
    parameter int MASK_SHIFT    = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                item_valid,
    input  lps_pkg::lps_func_t                  func,
    input  logic [lps_pkg::STEP_BYTE_W-1:0]     step_byte,
    input  logic                                last_byte,
    input  logic [lps_pkg::UNIT_TICKS_W-1:0]    unit_ticks,
    output logic [CHANNEL_COUNT-1:0]            lit_mask_next,
    output lps_pkg::lps_status_t                status_next
);

    import lps_pkg::*;

    localparam int IW = $clog2(PATTERN_DEPTH + 1);
    localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int TW = DURATION_BITS + UNIT_TICKS_W;
    localparam int XW = STEP_BYTE_W + CHANNEL_COUNT;
    localparam logic [IW-1:0] DEPTH_I = IW'(PATTERN_DEPTH);

    logic [IW-1:0]            pattern_length_reg, pattern_length_next;
    logic [IW-1:0]            play_index_reg, play_index_next;
    logic [IW-1:0]            write_index_reg, write_index_next;
    logic                     overflow_seen_reg, overflow_seen_next;
    logic [TW-1:0]            ticks_left_reg, ticks_left_next;
    logic [CHANNEL_COUNT-1:0] current_mask_reg, current_mask_next;
    logic                     active_reg, active_next;
    logic [STEP_BYTE_W-1:0]   first_byte_reg, first_byte_next;
    logic                     bypass_reg;
    logic [STEP_BYTE_W-1:0]   bypass_data_reg;

    logic                     ram_we;
    logic [STEP_BYTE_W-1:0]   ram_rdata;
    logic [STEP_BYTE_W-1:0]   stored_step;
    logic                     rejected;

    // Step decode for the step that starts now
    logic                     play_go;
    logic [STEP_BYTE_W-1:0]   play_byte;
    logic [DURATION_BITS-1:0] play_units;
    logic [XW-1:0]            play_shifted;
    logic [TW-1:0]            play_ticks;

    lps_ram #(
        .WIDTH (STEP_BYTE_W),
        .DEPTH (PATTERN_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (write_index_reg[AW-1:0]),
        .wdata (step_byte),
        .raddr (play_index_next[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Entry at play_index_reg, with a write to the same entry forwarded
    assign stored_step = bypass_reg ? bypass_data_reg : ram_rdata;

    assign play_units   = play_byte[DURATION_BITS-1:0];
    assign play_shifted = {{CHANNEL_COUNT{1'b0}}, play_byte} >> MASK_SHIFT;
    assign play_ticks   = TW'(play_units) * TW'(unit_ticks);

    always_comb begin
        pattern_length_next = pattern_length_reg;
        play_index_next     = play_index_reg;
        write_index_next    = write_index_reg;
        overflow_seen_next  = overflow_seen_reg;
        ticks_left_next     = ticks_left_reg;
        current_mask_next   = current_mask_reg;
        active_next         = active_reg;
        first_byte_next     = first_byte_reg;
        ram_we              = 1'b0;
        rejected            = 1'b0;
        play_go             = 1'b0;
        play_byte           = '0;

        if (item_valid) begin
            unique case (func)
                FUNC_LOAD: begin
                    // First byte of a load halts playback, mask stays lit
                    if (write_index_reg == '0 && !overflow_seen_reg) begin
                        active_next         = 1'b0;
                        pattern_length_next = '0;
                        play_index_next     = '0;
                        ticks_left_next     = '0;
                    end
                    if (write_index_reg < DEPTH_I) begin
                        ram_we           = 1'b1;
                        write_index_next = write_index_reg + 1'b1;
                        if (write_index_reg == '0) begin
                            first_byte_next = step_byte;
                        end
                    end else begin
                        overflow_seen_next = 1'b1;
                    end
                    if (last_byte) begin
                        if (overflow_seen_next) begin
                            rejected = 1'b1;
                        end else begin
                            // Start at step 0; the length is at least one
                            pattern_length_next = write_index_next;
                            play_index_next     = IW'(1);
                            play_go             = 1'b1;
                            play_byte = (write_index_reg == '0) ? step_byte : first_byte_reg;
                        end
                        write_index_next   = '0;
                        overflow_seen_next = 1'b0;
                    end
                end
                FUNC_TICK: begin
                    if (active_reg) begin
                        if (ticks_left_reg[TW-1:1] == '0) begin
                            play_go = 1'b1;
                            if (play_index_reg < pattern_length_reg) begin
                                play_byte       = stored_step;
                                play_index_next = play_index_reg + 1'b1;
                            end
                        end else begin
                            ticks_left_next = ticks_left_reg - 1'b1;
                        end
                    end
                end
                FUNC_OFF: begin
                    active_next         = 1'b0;
                    pattern_length_next = '0;
                    play_index_next     = '0;
                    ticks_left_next     = '0;
                    current_mask_next   = '0;
                end
                default: begin
                end
            endcase

            if (play_go) begin
                if (play_units == '0) begin
                    current_mask_next = '0;
                    active_next       = 1'b0;
                    ticks_left_next   = '0;
                end else begin
                    current_mask_next = play_shifted[CHANNEL_COUNT-1:0];
                    ticks_left_next   = play_ticks;
                    active_next       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= '0;
            play_index_reg     <= '0;
            write_index_reg    <= '0;
            overflow_seen_reg  <= 1'b0;
            ticks_left_reg     <= '0;
            current_mask_reg   <= '0;
            active_reg         <= 1'b0;
            bypass_reg         <= 1'b0;
        end else begin
            pattern_length_reg <= pattern_length_next;
            play_index_reg     <= play_index_next;
            write_index_reg    <= write_index_next;
            overflow_seen_reg  <= overflow_seen_next;
            ticks_left_reg     <= ticks_left_next;
            current_mask_reg   <= current_mask_next;
            active_reg         <= active_next;
            bypass_reg         <= ram_we && (write_index_reg == play_index_next);
        end
    end

    always_ff @(posedge aclk) begin
        first_byte_reg  <= first_byte_next;
        bypass_data_reg <= step_byte;
    end

    assign lit_mask_next               = current_mask_next;
    assign status_next.playing         = active_next;
    assign status_next.load_rejected   = rejected;

    // A timed step always belongs to a stored, non-empty pattern
    a_active_has_length: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (pattern_length_reg != '0))
        else $error("playing with an empty pattern");

    // No load is in progress while a step is timed
    a_active_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (write_index_reg == '0 && !overflow_seen_reg))
        else $error("load in progress during playback");

    a_idle_timer_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (ticks_left_reg == '0))
        else $error("step timer running while idle");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        play_index_reg <= pattern_length_reg)
        else $error("play index past pattern length");

    a_off_darkens: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && func == FUNC_OFF) |=> (current_mask_reg == '0 && !active_reg))
        else $error("off item left LEDs lit or playing");

endmodule

// ===== hdl/led_pattern_sequencer.sv =====
// Top level of the LED pattern sequencer: stream ports, unit_ticks register
// and result register. Depends on lps_pkg and lps_core (which uses lps_ram).
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  tdata step_byte, tuser func, tlast last_byte
//  m_        out        m_tvalid / m_tready  tdata lit_mask, playing, load_rejected
//  cfg_      in         cfg_valid/cfg_ready  cfg_data unit_ticks
//
// Every accepted item yields one result item in the next cycle, through the
// result register; while results are taken the block takes one item per cycle,
// the rate set by that single register stage. Reset (aresetn low, synchronous)
// clears playback, load state and the result register, sets unit_ticks to 1000.
// While a result waits on m_tready, s_tready stays high only if the waiting
// result is taken in the same cycle. cfg_ready is always high.
module led_pattern_sequencer #(
    parameter int PATTERN_DEPTH = 32,
    parameter int CHANNEL_COUNT = 3,
    parameter int DURATION_BITS = 5,
    parameter int MASK_SHIFT    = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lps_pkg::STEP_BYTE_W-1:0]     s_tdata,   // [7:0] step_byte
    input  logic [lps_pkg::FUNC_W-1:0]          s_tuser,   // [1:0] func
    input  logic                                s_tlast,   // last_byte
    // Result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((CHANNEL_COUNT + 2 + 7) / 8) * 8 - 1:0] m_tdata, // lit_mask, playing,
                                                           // load_rejected, zero fill
    // unit_ticks write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lps_pkg::UNIT_TICKS_W-1:0]    cfg_data
);

    import lps_pkg::*;

    localparam int RES_W    = CHANNEL_COUNT + 2;
    localparam int M_DATA_W = ((CHANNEL_COUNT + 2 + 7) / 8) * 8;

    logic                     s_accept;
    logic [UNIT_TICKS_W-1:0]  unit_ticks_reg;
    logic [CHANNEL_COUNT-1:0] lit_mask_next;
    lps_status_t              status_next;

    logic                     m_valid_reg, m_valid_next;
    logic [CHANNEL_COUNT-1:0] lit_mask_reg;
    lps_status_t              status_reg;

    // Take a new item whenever the result register is free or drains now
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_ticks_reg <= UNIT_TICKS_RESET;
        end else if (cfg_valid) begin
            unit_ticks_reg <= cfg_data;
        end
    end

    lps_core #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .DURATION_BITS (DURATION_BITS),
        .MASK_SHIFT    (MASK_SHIFT)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (s_accept),
        .func          (lps_func_t'(s_tuser)),
        .step_byte     (s_tdata),
        .last_byte     (s_tlast),
        .unit_ticks    (unit_ticks_reg),
        .lit_mask_next (lit_mask_next),
        .status_next   (status_next)
    );

    // Hold the result until taken; load a new one on every accepted item
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            lit_mask_reg <= lit_mask_next;
            status_reg   <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({status_reg.load_rejected, status_reg.playing, lit_mask_reg});

    // Result bit layout must fit the bus
    a_res_fits: assert property (@(posedge aclk) RES_W <= M_DATA_W)
        else $error("result fields exceed m_tdata");

endmodule

// ===== test/led_pattern_sequencer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for led_pattern_sequencer: streams load, tick and off
// items, predicts every result item in a scoreboard class and compares them.
// Depends on lps_pkg and the led_pattern_sequencer RTL.
module led_pattern_sequencer_tb;
    import lps_pkg::*;

    localparam int PATTERN_DEPTH   = 32;
    localparam int CHANNEL_COUNT   = 3;
    localparam int DURATION_BITS   = 5;
    localparam int MASK_SHIFT      = 5;
    localparam int RESULT_W        = 8;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int IDLE_PCT        = 34;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_REPORTS     = 10;

    // Result item as it sits in m_tdata, lit_mask in the lowest bits
    typedef struct packed {
        logic [RESULT_W-CHANNEL_COUNT-3:0] fill;
        logic                              load_rejected;
        logic                              playing;
        logic [CHANNEL_COUNT-1:0]          lit_mask;
    } led_result_t;

    // Tracks the sequencer's playback state and queues the result of each item
    class led_sequence_scoreboard;
        logic [STEP_BYTE_W-1:0]  steps [PATTERN_DEPTH];
        int unsigned             length = 0;
        int unsigned             play_idx = 0;
        int unsigned             write_idx = 0;
        bit                      overflow = 0;
        int unsigned             ticks_left = 0;
        logic [CHANNEL_COUNT-1:0] mask = '0;
        bit                      running = 0;
        logic [UNIT_TICKS_W-1:0] unit_ticks = UNIT_TICKS_RESET;
        led_result_t             awaited_leds [$];
        int                      mismatches = 0;
        int                      results_seen = 0;

        function void set_unit_ticks(logic [UNIT_TICKS_W-1:0] value);
            unit_ticks = value;
        endfunction

        function void halt_playback();
            running = 0;
            length = 0;
            play_idx = 0;
            ticks_left = 0;
        endfunction

        // Fetch the next step; a zero duration or the end of the pattern goes dark
        function void start_next_step();
            logic [STEP_BYTE_W-1:0] s;
            int unsigned units;
            s = '0;
            if (play_idx < length && play_idx < PATTERN_DEPTH) begin
                s = steps[play_idx];
                play_idx++;
            end
            units = 32'(s[DURATION_BITS-1:0]);
            if (units == 0) begin
                mask = '0;
                running = 0;
                ticks_left = 0;
            end else begin
                mask = s[MASK_SHIFT +: CHANNEL_COUNT];
                ticks_left = units * unit_ticks;
                running = 1;
            end
        endfunction

        function void note_input(logic [FUNC_W-1:0] func, logic [STEP_BYTE_W-1:0] step_byte,
                                 logic last_byte);
            led_result_t r;
            r = '0;
            case (func)
                FUNC_LOAD: begin
                    // first byte of a load halts playback but keeps the mask
                    if (write_idx == 0 && !overflow)
                        halt_playback();
                    if (write_idx < PATTERN_DEPTH) begin
                        steps[write_idx] = step_byte;
                        write_idx++;
                    end else begin
                        overflow = 1;
                    end
                    if (last_byte) begin
                        if (overflow) begin
                            r.load_rejected = 1'b1;
                        end else begin
                            length = write_idx;
                            play_idx = 0;
                            start_next_step();
                        end
                        write_idx = 0;
                        overflow = 0;
                    end
                end
                FUNC_TICK: begin
                    if (running) begin
                        if (ticks_left <= 1) begin
                            ticks_left = 0;
                            start_next_step();
                        end else begin
                            ticks_left--;
                        end
                    end
                end
                FUNC_OFF: begin
                    halt_playback();
                    mask = '0;
                end
                default: ;
            endcase
            r.lit_mask = mask;
            r.playing = running;
            awaited_leds.push_back(r);
        endfunction

        function void report_mismatch(string msg);
            if (mismatches < MAX_REPORTS)
                $display("%0t: result %0d: %s", $realtime, results_seen, msg);
            mismatches++;
        endfunction

        function void check_result(logic [RESULT_W-1:0] data);
            led_result_t got, want;
            got = data;
            results_seen++;
            if (awaited_leds.size() == 0) begin
                report_mismatch($sformatf("unexpected result %02h", data));
                return;
            end
            want = awaited_leds.pop_front();
            if (got.lit_mask !== want.lit_mask || got.playing !== want.playing ||
                got.load_rejected !== want.load_rejected || got.fill !== want.fill)
                report_mismatch($sformatf(
                    "expected mask %0h playing %0b rejected %0b fill %0h, got %0h %0b %0b %0h",
                    want.lit_mask, want.playing, want.load_rejected, want.fill,
                    got.lit_mask, got.playing, got.load_rejected, got.fill));
        endfunction

        function int pending();
            return awaited_leds.size();
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [STEP_BYTE_W-1:0]  s_tdata   = '0;   // [7:0] step_byte
    logic [FUNC_W-1:0]       s_tuser   = '0;   // [1:0] func
    logic                    s_tlast   = 1'b0; // last_byte
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [RESULT_W-1:0]     m_tdata;          // [2:0] lit_mask, [3] playing,
                                               // [4] load_rejected, [7:5] zero
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [UNIT_TICKS_W-1:0] cfg_data  = '0;

    led_sequence_scoreboard led_check = new();
    int  items_sent = 0;
    bit  no_idle = 0;
    bit  hold_off_req = 0;

    led_pattern_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Offer one item, idling first at random, and hold it until it is taken
    task automatic send_item(logic [FUNC_W-1:0] func, logic [STEP_BYTE_W-1:0] step_byte,
                             logic last_byte);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= step_byte;
        s_tlast  <= last_byte;
        do @(posedge aclk); while (!s_tready);
        led_check.note_input(func, step_byte, last_byte);
        items_sent++;
    endtask

    // Mostly short durations so patterns play out; some zero, some full range
    task automatic load_pattern(int n_bytes, bit finish);
        logic [STEP_BYTE_W-1:0] b;
        int r;
        for (int i = 0; i < n_bytes; i++) begin
            r = $urandom_range(99);
            b[7:5] = 3'($urandom_range(7));
            if (r < 10)
                b[4:0] = 5'd0;
            else if (r < 80)
                b[4:0] = 5'($urandom_range(3, 1));
            else
                b[4:0] = 5'($urandom_range(31));
            send_item(FUNC_LOAD, b, finish && (i == n_bytes - 1));
        end
    endtask

    task automatic run_ticks(int n);
        for (int i = 0; i < n; i++)
            send_item(FUNC_TICK, STEP_BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic random_phase(int n_items);
        int first, r;
        first = items_sent;
        while (items_sent - first < n_items) begin
            r = $urandom_range(99);
            if (r < 65) begin
                // complete pattern, now and then around or past the store depth
                if ($urandom_range(19) == 0)
                    load_pattern($urandom_range(36, 30), 1);
                else
                    load_pattern($urandom_range(6, 1), 1);
                run_ticks($urandom_range(25));
            end else if (r < 73) begin
                // off in the middle of a load, then finish the load
                load_pattern($urandom_range(3, 1), 0);
                send_item(FUNC_OFF, STEP_BYTE_W'($urandom_range(255)),
                          1'($urandom_range(1)));
                load_pattern($urandom_range(3, 1), 1);
                run_ticks($urandom_range(10));
            end else if (r < 80) begin
                // load left open; the next load continues it
                load_pattern($urandom_range(4, 1), 0);
                run_ticks($urandom_range(4));
            end else if (r < 88) begin
                send_item(FUNC_OFF, STEP_BYTE_W'($urandom_range(255)),
                          1'($urandom_range(1)));
            end else if (r < 94) begin
                send_item(FUNC_UNUSED, STEP_BYTE_W'($urandom_range(255)),
                          1'($urandom_range(1)));
            end else begin
                run_ticks($urandom_range(8, 1));
            end
        end
    endtask

    // Write unit_ticks only once every result is back and the block has settled
    task automatic write_unit_ticks(logic [UNIT_TICKS_W-1:0] value);
        s_tvalid <= 1'b0;
        while (led_check.pending() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        led_check.set_unit_ticks(value);
    endtask

    // Result side: random stalls, or one long hold-off when asked for
    initial begin
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 0;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            led_check.check_result(m_tdata);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("led_pattern_sequencer test failed");
        $finish;
    end

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset unit_ticks: idle items, then the longest step on all channels
        send_item(FUNC_TICK, 8'h00, 1'b0);
        send_item(FUNC_OFF, 8'hFF, 1'b1);
        send_item(FUNC_UNUSED, 8'hA5, 1'b1);
        send_item(FUNC_LOAD, 8'hFF, 1'b1);
        send_item(FUNC_TICK, 8'h5A, 1'b0);

        // three steps played through to the end of the pattern
        write_unit_ticks(16'd1);
        send_item(FUNC_LOAD, 8'h21, 1'b0);
        send_item(FUNC_LOAD, 8'hA2, 1'b0);
        send_item(FUNC_LOAD, 8'hE1, 1'b1);
        run_ticks(5);

        // new load keeps the lit mask; off during the load; dark step with time
        send_item(FUNC_LOAD, 8'hE3, 1'b1);
        send_item(FUNC_LOAD, 8'h40, 1'b0);
        send_item(FUNC_OFF, 8'h00, 1'b0);
        send_item(FUNC_LOAD, 8'h1F, 1'b1);
        send_item(FUNC_TICK, 8'h00, 1'b1);
        // zero duration stops at once; fields of a tick are ignored
        send_item(FUNC_LOAD, 8'hE0, 1'b1);
        send_item(FUNC_TICK, 8'hFF, 1'b1);

        write_unit_ticks(16'd1);
        hold_off_req = 1;
        random_phase(140);
        write_unit_ticks(16'hFFFF);
        random_phase(40);
        write_unit_ticks(16'd0);
        random_phase(110);
        write_unit_ticks(16'd3);
        random_phase(110);
        no_idle = 1;
        write_unit_ticks(16'd2);
        random_phase(110);
        no_idle = 0;
        write_unit_ticks(16'd1);
        random_phase(90);

        s_tvalid <= 1'b0;
        while (led_check.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (led_check.mismatches == 0 && led_check.pending() == 0)
            $display("led_pattern_sequencer test passed");
        else
            $display("led_pattern_sequencer test failed");
        $finish;
    end

endmodule
